/* hw/rtl/adp_pkg.sv */
// Package for the archive directory parser: parse phases, status codes,
// header constants and the result record type.
// No dependencies.
package adp_pkg;

    // Largest body window in bytes; directory bytes must lie below 8 + this
    localparam int unsigned BODY_WINDOW = 67108864;
    localparam logic [31:0] BODY_LIMIT  = 32'(8 + BODY_WINDOW);

    // Header bytes and limits
    localparam logic [7:0]  MAGIC_B0        = 8'h44;  // 'D'
    localparam logic [7:0]  MAGIC_B1        = 8'h53;  // 'S'
    localparam logic [7:0]  MAGIC_B2        = 8'h00;
    localparam logic [7:0]  OLD_VERSION_MAX = 8'h17;  // versions below carry a CRC16
    localparam logic [7:0]  WINDOW_MIN      = 8'd10;
    localparam logic [7:0]  WINDOW_MAX      = 8'd21;
    localparam logic [7:0]  CTRL_LIMIT      = 8'h20;
    localparam logic [7:0]  DEL_CHAR        = 8'h7f;
    localparam logic [3:0]  FIXED_LEN_NEW   = 4'd8;
    localparam logic [3:0]  FIXED_LEN_OLD   = 4'd10;
    localparam int unsigned FIXED_BYTES     = 10;
    localparam logic [31:0] MIN_FILE_LEN    = 32'd20;
    localparam logic [31:0] MIN_STREAM_LEN  = 32'd2;

    // Final status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_MAGIC   = 3'd1;
    localparam logic [2:0] ST_VERSION = 3'd2;
    localparam logic [2:0] ST_COUNT   = 3'd3;
    localparam logic [2:0] ST_WINDOW  = 3'd4;
    localparam logic [2:0] ST_NAME    = 3'd5;
    localparam logic [2:0] ST_TRUNC   = 3'd6;

    // Result kinds
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_FINAL  = 1'b1;

    // Parse phases, one-hot
    typedef enum logic [10:0] {
        PH_HEAD    = 11'b000_0000_0001,
        PH_NLEN1   = 11'b000_0000_0010,
        PH_NLEN2   = 11'b000_0000_0100,
        PH_NAME    = 11'b000_0000_1000,
        PH_XLEN1   = 11'b000_0001_0000,
        PH_XLEN2   = 11'b000_0010_0000,
        PH_XTRA    = 11'b000_0100_0000,
        PH_FIXED   = 11'b000_1000_0000,
        PH_STREAM  = 11'b001_0000_0000,
        PH_HALT    = 11'b010_0000_0000,
        PH_NAMEBAD = 11'b100_0000_0000
    } phase_t;

    // One result item
    typedef struct packed {
        logic        result_kind;
        logic [15:0] entry_index;
        logic [14:0] name_length;
        logic [31:0] size_value;
        logic [15:0] dos_time;
        logic [15:0] dos_date;
        logic [15:0] check_value;
        logic        check_present;
        logic [2:0]  status;
        logic [7:0]  format_version;
        logic [7:0]  window_order;
        logic [7:0]  pack_level;
    } result_t;

endpackage

/* hw/rtl/archive_directory_parser.sv */
// Archive directory parser: one byte per cycle while in_stall is low, header check, record walk.
// Results: each result is registered into the result register, or into the skid entry while a result is held.
// Throughput: one byte per cycle; a two-entry output stage (register + skid)
// keeps input flowing while a result waits, stall is raised only when both hold.
// Reset (rst_n low, asynchronous): header phase, all counters and status cleared.
// After the byte marked last the parser returns to that same state by itself.
module archive_directory_parser
    import adp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [15:0] entry_index,
    output logic [14:0] name_length,
    output logic [31:0] size_value,
    output logic [15:0] dos_time,
    output logic [15:0] dos_date,
    output logic [15:0] check_value,
    output logic        check_present,
    output logic [2:0]  status,
    output logic [7:0]  format_version,
    output logic [7:0]  window_order,
    output logic [7:0]  pack_level
);

    // Parser state
    phase_t      phase_reg, phase_next;
    logic [3:0]  fbc_reg, fbc_next;
    logic [15:0] entries_reg, entries_next;
    logic [15:0] recnum_reg, recnum_next;
    logic [14:0] length_reg, length_next;
    logic [14:0] skip_reg, skip_next;
    logic [7:0]  fixed_reg [FIXED_BYTES];
    logic [7:0]  fixed_next [FIXED_BYTES];
    logic [31:0] total_reg, total_next;
    logic [2:0]  error_reg, error_next;
    logic        old_reg, old_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  window_reg, window_next;
    logic [7:0]  level_reg, level_next;
    logic [31:0] start_reg, start_next;

    // Output stage
    logic        out_valid_reg, skid_valid_reg;
    result_t     out_reg, skid_reg;

    logic        accept;
    logic        out_fire;
    logic        rec;
    logic        res_valid;
    result_t     res;
    logic [31:0] pos;
    logic        in_body;
    logic        magic_bad;
    logic        name_bad;
    logic [14:0] skip_dec;
    logic [3:0]  fbc_inc;
    logic [15:0] entries_dec;
    logic [15:0] count_word;
    logic [14:0] len_word;
    logic [2:0]  final_status;

    assign accept   = in_valid & ~in_stall;
    assign out_fire = out_valid_reg & ~out_stall;
    assign in_stall = skid_valid_reg;

    // Next parser state for the byte on the input
    always_comb
    begin
        phase_next   = phase_reg;
        fbc_next     = fbc_reg;
        entries_next = entries_reg;
        recnum_next  = recnum_reg;
        length_next  = length_reg;
        skip_next    = skip_reg;
        fixed_next   = fixed_reg;
        error_next   = error_reg;
        old_next     = old_reg;
        version_next = version_reg;
        window_next  = window_reg;
        level_next   = level_reg;
        start_next   = start_reg;
        rec          = 1'b0;

        pos        = total_reg;
        total_next = (total_reg == 32'hffff_ffff) ? total_reg : total_reg + 32'd1;
        in_body    = (phase_reg != PH_HEAD) && (phase_reg != PH_STREAM)
                     && (phase_reg != PH_HALT);
        magic_bad  = ((fbc_reg == 4'd0) && (data_byte != MAGIC_B0))
                     || ((fbc_reg == 4'd1) && (data_byte != MAGIC_B1))
                     || ((fbc_reg == 4'd2) && (data_byte != MAGIC_B2));
        name_bad   = (phase_reg == PH_NAMEBAD) || (data_byte < CTRL_LIMIT)
                     || (data_byte == DEL_CHAR);
        skip_dec    = skip_reg - 15'd1;
        fbc_inc     = fbc_reg + 4'd1;
        entries_dec = entries_reg - 16'd1;
        count_word  = {data_byte, entries_reg[7:0]};
        len_word    = skip_reg | {7'd0, data_byte};

        if (accept)
        begin
            if (in_body && (pos >= BODY_LIMIT))
            begin
                // directory reaches past the body window
                error_next = ST_TRUNC;
                phase_next = PH_HALT;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEAD:
                    begin
                        if (magic_bad)
                        begin
                            error_next = ST_MAGIC;
                            phase_next = PH_HALT;
                        end
                        else
                        begin
                            fbc_next = fbc_inc;
                            case (fbc_reg)
                                4'd3:
                                begin
                                    if (data_byte == 8'd0)
                                    begin
                                        error_next = ST_VERSION;
                                        phase_next = PH_HALT;
                                    end
                                    else
                                    begin
                                        version_next = data_byte;
                                        old_next     = (data_byte < OLD_VERSION_MAX);
                                    end
                                end
                                4'd4:
                                begin
                                    entries_next = {8'd0, data_byte};
                                end
                                4'd5:
                                begin
                                    entries_next = count_word;
                                    if (count_word == 16'd0)
                                    begin
                                        error_next = ST_COUNT;
                                        phase_next = PH_HALT;
                                    end
                                end
                                4'd6:
                                begin
                                    if ((data_byte < WINDOW_MIN) || (data_byte > WINDOW_MAX))
                                    begin
                                        error_next = ST_WINDOW;
                                        phase_next = PH_HALT;
                                    end
                                    else
                                    begin
                                        window_next = data_byte;
                                    end
                                end
                                4'd7:
                                begin
                                    level_next = data_byte;
                                    phase_next = PH_NLEN1;
                                    fbc_next   = 4'd0;
                                end
                                default:
                                begin
                                    fbc_next = fbc_inc;
                                end
                            endcase
                        end
                    end
                    PH_NLEN1:
                    begin
                        if (data_byte[7])
                        begin
                            skip_next  = {data_byte[6:0], 8'd0};
                            phase_next = PH_NLEN2;
                        end
                        else
                        begin
                            length_next = {7'd0, data_byte};
                            if (data_byte == 8'd0)
                            begin
                                error_next = ST_NAME;
                                phase_next = PH_HALT;
                            end
                            else
                            begin
                                skip_next  = {7'd0, data_byte};
                                phase_next = PH_NAME;
                            end
                        end
                    end
                    PH_NLEN2:
                    begin
                        length_next = len_word;
                        if (len_word == 15'd0)
                        begin
                            error_next = ST_NAME;
                            phase_next = PH_HALT;
                        end
                        else
                        begin
                            skip_next  = len_word;
                            phase_next = PH_NAME;
                        end
                    end
                    PH_NAME, PH_NAMEBAD:
                    begin
                        // a bad name is reported only once all of it has arrived
                        skip_next = skip_dec;
                        if (skip_dec == 15'd0)
                        begin
                            if (name_bad)
                            begin
                                error_next = ST_NAME;
                                phase_next = PH_HALT;
                            end
                            else
                            begin
                                phase_next = PH_XLEN1;
                            end
                        end
                        else
                        begin
                            phase_next = name_bad ? PH_NAMEBAD : PH_NAME;
                        end
                    end
                    PH_XLEN1:
                    begin
                        if (data_byte[7])
                        begin
                            skip_next  = {data_byte[6:0], 8'd0};
                            phase_next = PH_XLEN2;
                        end
                        else
                        begin
                            skip_next  = {7'd0, data_byte};
                            fbc_next   = 4'd0;
                            phase_next = (data_byte == 8'd0) ? PH_FIXED : PH_XTRA;
                        end
                    end
                    PH_XLEN2:
                    begin
                        skip_next  = len_word;
                        fbc_next   = 4'd0;
                        phase_next = (len_word == 15'd0) ? PH_FIXED : PH_XTRA;
                    end
                    PH_XTRA:
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == 15'd0)
                        begin
                            fbc_next   = 4'd0;
                            phase_next = PH_FIXED;
                        end
                    end
                    PH_FIXED:
                    begin
                        if (fbc_reg < FIXED_LEN_OLD)
                        begin
                            fixed_next[fbc_reg] = data_byte;
                        end
                        fbc_next = fbc_inc;
                        if (fbc_inc >= (old_reg ? FIXED_LEN_OLD : FIXED_LEN_NEW))
                        begin
                            // record complete
                            rec          = 1'b1;
                            fbc_next     = 4'd0;
                            entries_next = entries_dec;
                            phase_next   = PH_NLEN1;
                            if (entries_dec == 16'd0)
                            begin
                                phase_next = PH_STREAM;
                                start_next = pos + 32'd1;
                            end
                        end
                    end
                    default:
                    begin
                        // stream body or halted: hold until the last byte
                        phase_next = phase_reg;
                    end
                endcase
            end
        end

        // Final status precedence
        if (total_next < MIN_FILE_LEN)
        begin
            final_status = ST_TRUNC;
        end
        else if (error_next != ST_OK)
        begin
            final_status = error_next;
        end
        else if (phase_next != PH_STREAM)
        begin
            final_status = ST_TRUNC;
        end
        else if ((total_next - start_next) < MIN_STREAM_LEN)
        begin
            final_status = ST_TRUNC;
        end
        else
        begin
            final_status = ST_OK;
        end

        // Build the result request
        res_valid = accept && (last_byte || rec);
        if (last_byte)
        begin
            res.result_kind    = KIND_FINAL;
            res.entry_index    = recnum_reg + {15'd0, rec};
            res.name_length    = 15'd0;
            res.size_value     = start_next;
            res.dos_time       = 16'd0;
            res.dos_date       = 16'd0;
            res.check_value    = 16'd0;
            res.check_present  = 1'b0;
            res.status         = final_status;
            res.format_version = version_next;
            res.window_order   = window_next;
            res.pack_level     = level_next;
        end
        else
        begin
            res.result_kind    = KIND_RECORD;
            res.entry_index    = recnum_reg;
            res.name_length    = length_reg;
            res.size_value     = {fixed_next[3], fixed_next[2], fixed_next[1], fixed_next[0]};
            res.dos_time       = {fixed_next[5], fixed_next[4]};
            res.dos_date       = {fixed_next[7], fixed_next[6]};
            res.check_value    = old_reg ? {fixed_next[9], fixed_next[8]} : 16'd0;
            res.check_present  = old_reg;
            res.status         = ST_OK;
            res.format_version = version_reg;
            res.window_order   = window_reg;
            res.pack_level     = level_reg;
        end

        if (accept && rec && !last_byte)
        begin
            recnum_next = recnum_reg + 16'd1;
        end

        // Drop back to the reset state after the last byte
        if (accept && last_byte)
        begin
            phase_next   = PH_HEAD;
            fbc_next     = 4'd0;
            entries_next = 16'd0;
            recnum_next  = 16'd0;
            length_next  = 15'd0;
            skip_next    = 15'd0;
            total_next   = 32'd0;
            error_next   = ST_OK;
            old_next     = 1'b0;
            version_next = 8'd0;
            window_next  = 8'd0;
            level_next   = 8'd0;
            start_next   = 32'd0;
        end
        else if (!accept)
        begin
            total_next = total_reg;
        end
    end

    // Parser control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEAD;
            fbc_reg     <= 4'd0;
            entries_reg <= 16'd0;
            recnum_reg  <= 16'd0;
            length_reg  <= 15'd0;
            skip_reg    <= 15'd0;
            total_reg   <= 32'd0;
            error_reg   <= ST_OK;
            old_reg     <= 1'b0;
            version_reg <= 8'd0;
            window_reg  <= 8'd0;
            level_reg   <= 8'd0;
            start_reg   <= 32'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            fbc_reg     <= fbc_next;
            entries_reg <= entries_next;
            recnum_reg  <= recnum_next;
            length_reg  <= length_next;
            skip_reg    <= skip_next;
            total_reg   <= total_next;
            error_reg   <= error_next;
            old_reg     <= old_next;
            version_reg <= version_next;
            window_reg  <= window_next;
            level_reg   <= level_next;
            start_reg   <= start_next;
        end
    end

    // Fixed-part byte store, rewritten for every record
    always_ff @(posedge clk)
    begin
        fixed_reg <= fixed_next;
    end

    // Output valid flags: result register plus skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload: advance from skid, or load the new request
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = out_reg.result_kind;
    assign entry_index    = out_reg.entry_index;
    assign name_length    = out_reg.name_length;
    assign size_value     = out_reg.size_value;
    assign dos_time       = out_reg.dos_time;
    assign dos_date       = out_reg.dos_date;
    assign check_value    = out_reg.check_value;
    assign check_present  = out_reg.check_present;
    assign status         = out_reg.status;
    assign format_version = out_reg.format_version;
    assign window_order   = out_reg.window_order;
    assign pack_level     = out_reg.pack_level;

    // Skid entry is only ever filled behind a held result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while result register empty");

    // A kept error always parks the parser
    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (error_reg != ST_OK) |-> (phase_reg == PH_HALT))
        else $error("error recorded without halting");

    // Fixed-part byte counter stays inside the store
    a_fixed_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FIXED) |-> (fbc_reg < FIXED_LEN_OLD))
        else $error("fixed-part counter out of range");

    // The last byte returns the parser to the header phase with a fresh count
    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_byte) |=> ((phase_reg == PH_HEAD) && (total_reg == 32'd0)))
        else $error("parser did not restart after last byte");

endmodule

/* tb/archive_directory_parser_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for archive_directory_parser: streams archive files one request
// at a time, predicts each directory record and final status, and checks every result.
// Depends on adp_pkg and the archive_directory_parser RTL.
module archive_directory_parser_tb;
    import adp_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 10;
    localparam int ITEM_TARGET  = 700;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 300;
    localparam int REPORT_LIMIT = 10;

    typedef enum int {
        FAULT_NONE,
        FAULT_MAGIC,
        FAULT_VERSION,
        FAULT_COUNT,
        FAULT_WINDOW,
        FAULT_EMPTY_NAME,
        FAULT_CTRL_NAME,
        FAULT_CUT,
        FAULT_NOISE,
        FAULT_JUNK
    } fault_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        result_t    want;
    } byte_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic        result_kind;
    logic [15:0] entry_index;
    logic [14:0] name_length;
    logic [31:0] size_value;
    logic [15:0] dos_time;
    logic [15:0] dos_date;
    logic [15:0] check_value;
    logic        check_present;
    logic [2:0]  status;
    logic [7:0]  format_version;
    logic [7:0]  window_order;
    logic [7:0]  pack_level;

    // Shadow copy of the directory walk
    phase_t      dir_phase;
    logic [3:0]  dir_fcount;
    logic [15:0] dir_left;
    logic [15:0] dir_recno;
    logic [14:0] dir_len;
    logic [14:0] dir_skip;
    logic [7:0]  dir_fixed [FIXED_BYTES];
    logic [31:0] dir_total;
    logic [2:0]  dir_err;
    logic        dir_old;
    logic [23:0] dir_hdr;
    logic [31:0] dir_sstart;

    result_t     directory_results_q [$];
    byte_row_t   directed_rows [$];
    logic [7:0]  archive_bytes [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int mismatches    = 0;
    int results_seen  = 0;
    int quiet_cycles  = 0;

    archive_directory_parser i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .entry_index    (entry_index),
        .name_length    (name_length),
        .size_value     (size_value),
        .dos_time       (dos_time),
        .dos_date       (dos_date),
        .check_value    (check_value),
        .check_present  (check_present),
        .status         (status),
        .format_version (format_version),
        .window_order   (window_order),
        .pack_level     (pack_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Return the shadow walk to its post-reset state
    function automatic void clear_directory();
        dir_phase  = PH_HEAD;
        dir_fcount = '0;
        dir_left   = '0;
        dir_recno  = '0;
        dir_len    = '0;
        dir_skip   = '0;
        dir_total  = '0;
        dir_err    = ST_OK;
        dir_old    = 1'b0;
        dir_hdr    = '0;
        dir_sstart = '0;
        for (int i = 0; i < FIXED_BYTES; i++)
            dir_fixed[i] = '0;
    endfunction

    function automatic void halt_directory(input logic [2:0] code);
        dir_err   = code;
        dir_phase = PH_HALT;
    endfunction

    function automatic void take_name_length();
        if (dir_len == '0)
            halt_directory(ST_NAME);
        else
        begin
            dir_skip  = dir_len;
            dir_phase = PH_NAME;
        end
    endfunction

    function automatic void take_extra_length();
        dir_fcount = '0;
        dir_phase  = (dir_skip == '0) ? PH_FIXED : PH_XTRA;
    endfunction

    function automatic logic [15:0] fixed_le16(input int at);
        return {dir_fixed[at + 1], dir_fixed[at]};
    endfunction

    function automatic result_t final_status(input logic [15:0] entries,
                                             input logic [31:0] offset,
                                             input logic [2:0]  st,
                                             input logic [23:0] hdr);
        result_t r;
        r                = '0;
        r.result_kind    = KIND_FINAL;
        r.entry_index    = entries;
        r.size_value     = offset;
        r.status         = st;
        r.format_version = hdr[7:0];
        r.window_order   = hdr[15:8];
        r.pack_level     = hdr[23:16];
        return r;
    endfunction

    // Advance the walk by one byte; return 1 when a record has just completed
    function automatic bit step_directory(input logic [7:0] b, input logic [31:0] pos);
        logic bad;
        bit   in_dir;
        in_dir = (dir_phase != PH_HEAD) && (dir_phase != PH_STREAM) && (dir_phase != PH_HALT);
        if (in_dir && pos >= BODY_LIMIT)
        begin
            halt_directory(ST_TRUNC);
            return 0;
        end
        case (dir_phase)
            PH_HEAD:
            begin
                if ((dir_fcount == 4'd0 && b != MAGIC_B0) ||
                    (dir_fcount == 4'd1 && b != MAGIC_B1) ||
                    (dir_fcount == 4'd2 && b != MAGIC_B2))
                begin
                    halt_directory(ST_MAGIC);
                    return 0;
                end
                case (dir_fcount)
                    4'd3:
                    begin
                        if (b == 8'h00)
                        begin
                            halt_directory(ST_VERSION);
                            return 0;
                        end
                        dir_hdr[7:0] = b;
                        dir_old      = (b < OLD_VERSION_MAX);
                    end
                    4'd4: dir_left = {8'h00, b};
                    4'd5:
                    begin
                        dir_left[15:8] = b;
                        if (dir_left == '0)
                        begin
                            halt_directory(ST_COUNT);
                            return 0;
                        end
                    end
                    4'd6:
                    begin
                        if (b < WINDOW_MIN || b > WINDOW_MAX)
                        begin
                            halt_directory(ST_WINDOW);
                            return 0;
                        end
                        dir_hdr[15:8] = b;
                    end
                    4'd7:
                    begin
                        dir_hdr[23:16] = b;
                        dir_phase      = PH_NLEN1;
                        dir_fcount     = '0;
                        return 0;
                    end
                    default: ;
                endcase
                dir_fcount = dir_fcount + 4'd1;
                return 0;
            end
            PH_NLEN1:
            begin
                if (b[7])
                begin
                    dir_skip  = {b[6:0], 8'h00};
                    dir_phase = PH_NLEN2;
                end
                else
                begin
                    dir_len = {7'h00, b};
                    take_name_length();
                end
                return 0;
            end
            PH_NLEN2:
            begin
                dir_len = dir_skip | {7'h00, b};
                take_name_length();
                return 0;
            end
            PH_NAME, PH_NAMEBAD:
            begin
                // Hold a bad name until its last byte, so a cut name reads as truncation
                bad       = (dir_phase == PH_NAMEBAD) || (b < CTRL_LIMIT) || (b == DEL_CHAR);
                dir_phase = bad ? PH_NAMEBAD : PH_NAME;
                dir_skip  = dir_skip - 15'd1;
                if (dir_skip == '0)
                begin
                    if (bad)
                        halt_directory(ST_NAME);
                    else
                        dir_phase = PH_XLEN1;
                end
                return 0;
            end
            PH_XLEN1:
            begin
                if (b[7])
                begin
                    dir_skip  = {b[6:0], 8'h00};
                    dir_phase = PH_XLEN2;
                end
                else
                begin
                    dir_skip = {7'h00, b};
                    take_extra_length();
                end
                return 0;
            end
            PH_XLEN2:
            begin
                dir_skip = dir_skip | {7'h00, b};
                take_extra_length();
                return 0;
            end
            PH_XTRA:
            begin
                dir_skip = dir_skip - 15'd1;
                if (dir_skip == '0)
                begin
                    dir_fcount = '0;
                    dir_phase  = PH_FIXED;
                end
                return 0;
            end
            PH_FIXED:
            begin
                if (dir_fcount < FIXED_BYTES)
                    dir_fixed[dir_fcount] = b;
                dir_fcount = dir_fcount + 4'd1;
                if (dir_fcount >= (dir_old ? FIXED_LEN_OLD : FIXED_LEN_NEW))
                begin
                    dir_fcount = '0;
                    dir_left   = dir_left - 16'd1;
                    dir_phase  = PH_NLEN1;
                    if (dir_left == '0)
                    begin
                        dir_phase  = PH_STREAM;
                        dir_sstart = pos + 32'd1;
                    end
                    return 1;
                end
                return 0;
            end
            default: return 0;
        endcase
    endfunction

    // Work out the result, if any, that one accepted request causes
    function automatic bit predict_result(input logic [7:0] b, input logic last,
                                          output result_t r);
        logic [31:0] pos;
        bit          rec;
        logic [2:0]  st;
        r   = '0;
        pos = dir_total;
        if (dir_total != 32'hFFFF_FFFF)
            dir_total = dir_total + 32'd1;
        rec = step_directory(b, pos);
        if (last)
        begin
            if (dir_total < MIN_FILE_LEN)
                st = ST_TRUNC;
            else if (dir_err != ST_OK)
                st = dir_err;
            else if (dir_phase != PH_STREAM)
                st = ST_TRUNC;
            else if (dir_total - dir_sstart < MIN_STREAM_LEN)
                st = ST_TRUNC;
            else
                st = ST_OK;
            r = final_status(dir_recno + 16'(rec), dir_sstart, st, dir_hdr);
            clear_directory();
            return 1;
        end
        if (rec)
        begin
            r.result_kind    = KIND_RECORD;
            r.entry_index    = dir_recno;
            r.name_length    = dir_len;
            r.size_value     = {fixed_le16(2), fixed_le16(0)};
            r.dos_time       = fixed_le16(4);
            r.dos_date       = fixed_le16(6);
            r.check_value    = dir_old ? fixed_le16(8) : 16'h0000;
            r.check_present  = dir_old;
            r.status         = ST_OK;
            r.format_version = dir_hdr[7:0];
            r.window_order   = dir_hdr[15:8];
            r.pack_level     = dir_hdr[23:16];
            dir_recno        = dir_recno + 16'd1;
            return 1;
        end
        return 0;
    endfunction

    function automatic void add_row(input logic [7:0] b, input logic last = 1'b0,
                                    input logic typed = 1'b0, input result_t want = '0);
        byte_row_t row;
        row.data  = b;
        row.last  = last;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    // Append a name or extra length in the one- or two-byte code
    function automatic void push_length(input int v);
        if (v > 127 || $urandom_range(3) == 0)
        begin
            archive_bytes.push_back(8'(8'h80 | (v >> 8)));
            archive_bytes.push_back(8'(v & 255));
        end
        else
            archive_bytes.push_back(8'(v));
    endfunction

    // Build one archive file, mostly well formed, sometimes broken on purpose
    function automatic void build_archive();
        fault_t      fault;
        int          pick;
        int          count;
        int          fault_rec;
        int          n;
        int          x;
        int          flen;
        int          fill;
        int          pos;
        logic [7:0]  ver;
        logic [7:0]  b;
        logic [15:0] count_field;
        archive_bytes.delete();
        pick = $urandom_range(99);
        if (pick < 55)      fault = FAULT_NONE;
        else if (pick < 60) fault = FAULT_MAGIC;
        else if (pick < 64) fault = FAULT_VERSION;
        else if (pick < 68) fault = FAULT_COUNT;
        else if (pick < 73) fault = FAULT_WINDOW;
        else if (pick < 78) fault = FAULT_EMPTY_NAME;
        else if (pick < 84) fault = FAULT_CTRL_NAME;
        else if (pick < 92) fault = FAULT_CUT;
        else if (pick < 96) fault = FAULT_NOISE;
        else                fault = FAULT_JUNK;

        // Short file of raw noise
        if (fault == FAULT_JUNK)
        begin
            n = $urandom_range(1, 30);
            repeat (n) archive_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end

        // Header
        ver = $urandom_range(1) ? 8'($urandom_range(1, OLD_VERSION_MAX - 1))
                                : 8'($urandom_range(OLD_VERSION_MAX, 255));
        if (fault == FAULT_VERSION)
            ver = 8'h00;
        count       = $urandom_range(1, 3);
        count_field = 16'(count);
        if ($urandom_range(9) == 0)
            count_field = $urandom_range(1) ? 16'hFFFF : (16'h0100 | 16'(count));
        if (fault == FAULT_COUNT)
            count_field = 16'h0000;
        archive_bytes.push_back(MAGIC_B0);
        archive_bytes.push_back(MAGIC_B1);
        archive_bytes.push_back(MAGIC_B2);
        archive_bytes.push_back(ver);
        archive_bytes.push_back(count_field[7:0]);
        archive_bytes.push_back(count_field[15:8]);
        if (fault == FAULT_WINDOW)
            archive_bytes.push_back($urandom_range(1) ? 8'($urandom_range(0, WINDOW_MIN - 1))
                                                      : 8'($urandom_range(WINDOW_MAX + 1, 255)));
        else
            archive_bytes.push_back(8'($urandom_range(WINDOW_MIN, WINDOW_MAX)));
        archive_bytes.push_back(8'($urandom_range(0, 255)));
        if (fault == FAULT_MAGIC)
        begin
            pos = $urandom_range(0, 2);
            archive_bytes[pos] = archive_bytes[pos] ^ 8'($urandom_range(1, 255));
        end

        // Directory records
        fault_rec = $urandom_range(0, count - 1);
        for (int r = 0; r < count; r++)
        begin
            n = ($urandom_range(7) == 0) ? $urandom_range(128, 300) : $urandom_range(1, 6);
            if (fault == FAULT_EMPTY_NAME && r == fault_rec)
                n = 0;
            push_length(n);
            for (int k = 0; k < n; k++)
            begin
                b = 8'($urandom_range(CTRL_LIMIT, 255));
                if (b == DEL_CHAR)
                    b = DEL_CHAR - 8'd1;
                archive_bytes.push_back(b);
            end
            if (fault == FAULT_CTRL_NAME && r == fault_rec && n > 0)
            begin
                pos = archive_bytes.size() - $urandom_range(1, n);
                archive_bytes[pos] = $urandom_range(1) ? DEL_CHAR
                                                       : 8'($urandom_range(0, CTRL_LIMIT - 1));
            end
            x = ($urandom_range(7) == 0) ? $urandom_range(128, 160) : $urandom_range(0, 3);
            push_length(x);
            repeat (x) archive_bytes.push_back(8'($urandom_range(0, 255)));
            flen = (ver < OLD_VERSION_MAX) ? FIXED_LEN_OLD : FIXED_LEN_NEW;
            fill = $urandom_range(9);
            repeat (flen)
                archive_bytes.push_back(fill == 0 ? 8'hFF :
                                        fill == 1 ? 8'h00 : 8'($urandom_range(0, 255)));
        end

        // Coded stream, possibly empty so that the last record ends the file
        repeat ($urandom_range(0, 5)) archive_bytes.push_back(8'($urandom_range(0, 255)));

        if (fault == FAULT_CUT)
        begin
            n = $urandom_range(1, archive_bytes.size());
            while (archive_bytes.size() > n)
                void'(archive_bytes.pop_back());
        end
        if (fault == FAULT_NOISE)
            archive_bytes[$urandom_range(0, archive_bytes.size() - 1)] = 8'($urandom_range(0, 255));
    endfunction

    // Offer one request from a falling edge and return at the falling edge after acceptance
    task automatic send_request(input logic [7:0] b, input logic last,
                                input logic typed, input result_t want);
        result_t predicted;
        bit      has;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        data_byte = b;
        last_byte = last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        has = predict_result(b, last, predicted);
        if (typed)
            directory_results_q.push_back(want);
        else if (has)
            directory_results_q.push_back(predicted);
        items_sent++;
        @(negedge clk);
    endtask

    // Receiver: a long hold when asked, random stall otherwise
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
                out_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic void check_field(input string fname, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("result %0d: %s expected %0h, got %0h", results_seen, fname, want, got);
        end
    endfunction

    // Compare each accepted result with the oldest prediction; watch for a hang
    always @(posedge clk)
    begin : result_monitor
        result_t got;
        result_t want;
        if (out_valid === 1'b1 && out_stall == 1'b0)
        begin
            got.result_kind    = result_kind;
            got.entry_index    = entry_index;
            got.name_length    = name_length;
            got.size_value     = size_value;
            got.dos_time       = dos_time;
            got.dos_date       = dos_date;
            got.check_value    = check_value;
            got.check_present  = check_present;
            got.status         = status;
            got.format_version = format_version;
            got.window_order   = window_order;
            got.pack_level     = pack_level;
            if (directory_results_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %0d: nothing awaited, got kind %0d entry %0d status %0d",
                             results_seen, got.result_kind, got.entry_index, got.status);
            end
            else
            begin
                want = directory_results_q.pop_front();
                check_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
                check_field("entry_index", 32'(want.entry_index), 32'(got.entry_index));
                check_field("name_length", 32'(want.name_length), 32'(got.name_length));
                check_field("size_value", want.size_value, got.size_value);
                check_field("dos_time", 32'(want.dos_time), 32'(got.dos_time));
                check_field("dos_date", 32'(want.dos_date), 32'(got.dos_date));
                check_field("check_value", 32'(want.check_value), 32'(got.check_value));
                check_field("check_present", 32'(want.check_present), 32'(got.check_present));
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("format_version", 32'(want.format_version),
                            32'(got.format_version));
                check_field("window_order", 32'(want.window_order), 32'(got.window_order));
                check_field("pack_level", 32'(want.pack_level), 32'(got.pack_level));
            end
            results_seen++;
        end
        if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase_end;
        int base;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        data_byte = 8'h00;
        last_byte = 1'b0;
        clear_directory();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: a one-byte file, then an old-layout file at the field extremes
        add_row(8'h00, 1'b1, 1'b1, final_status(16'd0, 32'd0, ST_TRUNC, 24'h000000));
        add_row(MAGIC_B0);
        add_row(MAGIC_B1);
        add_row(MAGIC_B2);
        add_row(8'h01);
        add_row(8'h01);
        add_row(8'h00);
        add_row(WINDOW_MIN);
        add_row(8'hFF);
        add_row(8'h80);
        add_row(8'h01);
        add_row(8'h7E);
        add_row(8'h80);
        add_row(8'h00);
        repeat (FIXED_LEN_OLD) add_row(8'hFF);
        add_row(8'h00);
        add_row(8'h00, 1'b1, 1'b1, final_status(16'd1, 32'd23, ST_OK, {8'hFF, WINDOW_MIN, 8'h01}));

        send_idle_pct = 28;
        recv_idle_pct = 79;
        foreach (directed_rows[i])
            send_request(directed_rows[i].data, directed_rows[i].last,
                         directed_rows[i].typed, directed_rows[i].want);

        // Random files in three idling phases; drain between phases
        base = items_sent;
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 79 : 0;
            recv_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 28 : 0;
            if (ph == 2)
                hold_left = LONG_HOLD;
            phase_end = base + (ph + 1) * ITEM_TARGET / 3;
            while (items_sent < phase_end)
            begin
                build_archive();
                // Cut the closing file of a phase short at the phase boundary
                while (archive_bytes.size() > 1 && items_sent + archive_bytes.size() > phase_end)
                    void'(archive_bytes.pop_back());
                foreach (archive_bytes[k])
                    send_request(archive_bytes[k], k == archive_bytes.size() - 1, 1'b0, '0);
            end
            in_valid = 1'b0;
            while (directory_results_q.size() != 0)
                @(negedge clk);
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (directory_results_q.size() != 0)
        begin
            mismatches++;
            $display("%0d predicted results never arrived", directory_results_q.size());
        end
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
